// ===== rtl/lofb_pkg.sv =====
package lofb_pkg;

    localparam int FADE_FRAC_BITS = 16;

    localparam int FRAME_W = 32;
    localparam int PIX_W   = 8;
    localparam int DEN_W   = 16;
    localparam int NUM_CH  = 3;

    // fade factor k runs up to 1.0 inclusive
    localparam int K_W     = FADE_FRAC_BITS + 1;
    localparam int REM_W   = DEN_W + 1;

    // request edge to result-accept edge: two front stages, one divider stage
    // per quotient bit, four back stages
    localparam int LATENCY = K_W + 6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN_FRAMES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT_FRAMES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SWAP_RED_BLUE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_YUV_MODE        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAY_ONLY       = 3'd6;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [NUM_CH-1:0][PIX_W-1:0] v;
        logic [NUM_CH-1:0][PIX_W-1:0] l;
        logic [PIX_W-1:0]             op;
        logic                         site;
        logic                         in_range;
        logic                         fade;
    } t_pix;

endpackage

// ===== rtl/lofb_div.sv =====
module lofb_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic [lofb_pkg::DEN_W-1:0]        i_num,
    input  logic [lofb_pkg::DEN_W-1:0]        i_den,
    input  lofb_pkg::t_pix                    i_side,
    output logic                              o_valid,
    output logic [lofb_pkg::K_W-1:0]          o_quo,
    output lofb_pkg::t_pix                    o_side
);

    localparam int K_W   = lofb_pkg::K_W;
    localparam int REM_W = lofb_pkg::REM_W;
    localparam int DEN_W = lofb_pkg::DEN_W;

    // restoring divider, one quotient bit per stage, MSB first;
    // num <= den so the top quotient bit is the integer part
    logic [K_W-1:0]              r_valid;
    logic [K_W-1:0][REM_W-1:0]   r_rem;
    logic [K_W-1:0][DEN_W-1:0]   r_den;
    logic [K_W-1:0][K_W-1:0]     r_quo;
    lofb_pkg::t_pix [K_W-1:0]    r_side;

    for (genvar s = 0; s < K_W; s++) begin : g_stage
        logic [REM_W-1:0]  w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [K_W-1:0]    w_quo;
        logic              w_vld;
        lofb_pkg::t_pix    w_side;
        logic              w_ge;
        logic [REM_W-1:0]  w_diff;

        if (s == 0) begin : g_first
            assign w_rem  = {1'b0, i_num};
            assign w_den  = i_den;
            assign w_quo  = '0;
            assign w_vld  = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_rem  = r_rem[s-1];
            assign w_den  = r_den[s-1];
            assign w_quo  = r_quo[s-1];
            assign w_vld  = r_valid[s-1];
            assign w_side = r_side[s-1];
        end

        assign w_ge   = (w_rem >= {1'b0, w_den});
        assign w_diff = w_ge ? (w_rem - {1'b0, w_den}) : w_rem;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= w_vld;
            end
            r_rem[s]  <= {w_diff[REM_W-2:0], 1'b0};
            r_den[s]  <= w_den;
            r_quo[s]  <= w_quo | (K_W'(w_ge) << (K_W - 1 - s));
            r_side[s] <= w_side;
        end
    end

    assign o_valid = r_valid[K_W-1];
    assign o_quo   = r_quo[K_W-1];
    assign o_side  = r_side[K_W-1];

endmodule

// ===== rtl/logo_overlay_fade_blender_core.sv =====
// Logo overlay blender with fade ramp, one pixel of the overlay area per request.
//
// Request channel: drive the frame number, the video and logo channel bytes,
// the logo opacity and the chroma-site flag, and raise start. The request is
// taken at a rising edge where start is high and busy is low. busy is only
// high while in reset and for the cycle after it, so a request can be taken
// on every clock.
// Result channel: o_strobe is high for one cycle with o_out_c0..2 and
// o_was_changed; results come back in request order.
// The receiver cannot stall; nothing here waits on it.
// Latency is set by the fade-factor divider, which resolves one quotient bit
// per stage (FADE_FRAC_BITS + 1 stages), plus two front stages for the range
// and ramp decode and four back stages for opacity, multiply and the /255.
// Throughput: one pixel per clock.
// Configuration: i_cfg_we / i_cfg_idx / i_cfg_wdata write one register per
// clock; change it only while no pixels are in flight.
// Reset (synchronous, active low) empties the pipeline and restores the
// register defaults: full frame range, no ramps, RGB, no swap.
module logo_overlay_fade_blender_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [lofb_pkg::FRAME_W-1:0]           i_frame_number,
    input  logic [lofb_pkg::PIX_W-1:0]             i_video_c0,
    input  logic [lofb_pkg::PIX_W-1:0]             i_video_c1,
    input  logic [lofb_pkg::PIX_W-1:0]             i_video_c2,
    input  logic [lofb_pkg::PIX_W-1:0]             i_logo_c0,
    input  logic [lofb_pkg::PIX_W-1:0]             i_logo_c1,
    input  logic [lofb_pkg::PIX_W-1:0]             i_logo_c2,
    input  logic [lofb_pkg::PIX_W-1:0]             i_logo_opacity,
    input  logic                                   i_chroma_site,
    input  logic                                   i_cfg_we,
    input  logic [lofb_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [lofb_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    output logic                                   o_strobe,
    output logic [lofb_pkg::PIX_W-1:0]             o_out_c0,
    output logic [lofb_pkg::PIX_W-1:0]             o_out_c1,
    output logic [lofb_pkg::PIX_W-1:0]             o_out_c2,
    output logic                                   o_was_changed
);

    localparam int FRAME_W = lofb_pkg::FRAME_W;
    localparam int PIX_W   = lofb_pkg::PIX_W;
    localparam int DEN_W   = lofb_pkg::DEN_W;
    localparam int K_W     = lofb_pkg::K_W;
    localparam int NUM_CH  = lofb_pkg::NUM_CH;
    localparam int PROD_W  = PIX_W + K_W;
    localparam int MUL_W   = 2 * PIX_W;

    // exact floor(x / 255) for x up to 255 * 255
    function automatic logic [PIX_W-1:0] div255(input logic [MUL_W-1:0] x);
        logic [MUL_W:0] t;
        t = {1'b0, x} + (MUL_W+1)'(1);
        t = t + (t >> PIX_W);
        return t[MUL_W-1:PIX_W];
    endfunction

    // ---------------- configuration ----------------
    logic [FRAME_W-1:0] r_range_start;
    logic [FRAME_W-1:0] r_range_end;
    logic [DEN_W-1:0]   r_fade_in;
    logic [DEN_W-1:0]   r_fade_out;
    logic               r_swap;
    logic               r_yuv;
    logic               r_gray;
    logic               r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_start <= '0;
            r_range_end   <= '1;
            r_fade_in     <= '0;
            r_fade_out    <= '0;
            r_swap        <= 1'b0;
            r_yuv         <= 1'b0;
            r_gray        <= 1'b0;
            r_busy        <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    lofb_pkg::CFG_RANGE_START:     r_range_start <= i_cfg_wdata;
                    lofb_pkg::CFG_RANGE_END:       r_range_end   <= i_cfg_wdata;
                    lofb_pkg::CFG_FADE_IN_FRAMES:  r_fade_in     <= i_cfg_wdata[DEN_W-1:0];
                    lofb_pkg::CFG_FADE_OUT_FRAMES: r_fade_out    <= i_cfg_wdata[DEN_W-1:0];
                    lofb_pkg::CFG_SWAP_RED_BLUE:   r_swap        <= i_cfg_wdata[0];
                    lofb_pkg::CFG_YUV_MODE:        r_yuv         <= i_cfg_wdata[0];
                    lofb_pkg::CFG_GRAY_ONLY:       r_gray        <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    assign busy = r_busy;

    logic w_accept;
    assign w_accept = start && !r_busy;

    // ---------------- stage 1: range check ----------------
    lofb_pkg::t_pix     n_s1_pix;
    logic               w_swap_eff;
    logic               r_s1_valid;
    lofb_pkg::t_pix     r_s1_pix;
    logic [FRAME_W-1:0] r_s1_from_start;
    logic [FRAME_W-1:0] r_s1_to_end;

    assign w_swap_eff = r_swap && !r_yuv;

    always_comb begin
        n_s1_pix.v[0]    = i_video_c0;
        n_s1_pix.v[1]    = i_video_c1;
        n_s1_pix.v[2]    = i_video_c2;
        n_s1_pix.l[0]    = w_swap_eff ? i_logo_c2 : i_logo_c0;
        n_s1_pix.l[1]    = i_logo_c1;
        n_s1_pix.l[2]    = w_swap_eff ? i_logo_c0 : i_logo_c2;
        n_s1_pix.op      = i_logo_opacity;
        n_s1_pix.site    = i_chroma_site;
        n_s1_pix.in_range = (i_frame_number >= r_range_start) &&
                            (i_frame_number <= r_range_end);
        n_s1_pix.fade    = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
        end
        r_s1_pix        <= n_s1_pix;
        r_s1_from_start <= i_frame_number - r_range_start;
        r_s1_to_end     <= r_range_end - i_frame_number;
    end

    // ---------------- stage 2: ramp select ----------------
    logic               w_fin_hit;
    logic               w_fout_hit;
    logic [DEN_W-1:0]   n_s2_num;
    logic [DEN_W-1:0]   n_s2_den;
    lofb_pkg::t_pix     n_s2_pix;
    logic               r_s2_valid;
    logic [DEN_W-1:0]   r_s2_num;
    logic [DEN_W-1:0]   r_s2_den;
    lofb_pkg::t_pix     r_s2_pix;

    assign w_fin_hit  = (r_s1_from_start[FRAME_W-1:DEN_W] == '0) &&
                        (r_s1_from_start[DEN_W-1:0] < r_fade_in);
    assign w_fout_hit = (r_s1_to_end[FRAME_W-1:DEN_W] == '0) &&
                        (r_s1_to_end[DEN_W-1:0] < r_fade_out);

    // fade-in takes priority when both ramps cover the frame
    always_comb begin
        n_s2_pix = r_s1_pix;
        if (w_fin_hit) begin
            n_s2_num = r_fade_in - r_s1_from_start[DEN_W-1:0];
            n_s2_den = r_fade_in;
        end else if (w_fout_hit) begin
            n_s2_num = r_fade_out - r_s1_to_end[DEN_W-1:0];
            n_s2_den = r_fade_out;
        end else begin
            n_s2_num = '0;
            n_s2_den = '0;
        end
        n_s2_pix.fade = r_s1_pix.in_range && (w_fin_hit || w_fout_hit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
        r_s2_num <= n_s2_num;
        r_s2_den <= n_s2_den;
        r_s2_pix <= n_s2_pix;
    end

    // ---------------- fade factor k = num * 2^F / den ----------------
    logic               w_div_valid;
    logic [K_W-1:0]     w_div_k;
    lofb_pkg::t_pix     w_div_pix;

    lofb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s2_valid),
        .i_num   (r_s2_num),
        .i_den   (r_s2_den),
        .i_side  (r_s2_pix),
        .o_valid (w_div_valid),
        .o_quo   (w_div_k),
        .o_side  (w_div_pix)
    );

    // ---------------- stage A: opacity increment ----------------
    logic [PROD_W-1:0]  w_inc_prod;
    logic               r_sa_valid;
    logic [PIX_W:0]     r_sa_inc;
    lofb_pkg::t_pix     r_sa_pix;

    assign w_inc_prod = PROD_W'(lofb_pkg::PIX_MAX - w_div_pix.op) * PROD_W'(w_div_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_valid <= 1'b0;
        end else begin
            r_sa_valid <= w_div_valid;
        end
        r_sa_inc <= w_div_pix.fade ? w_inc_prod[lofb_pkg::FADE_FRAC_BITS +: PIX_W+1] : '0;
        r_sa_pix <= w_div_pix;
    end

    // ---------------- stage C: effective opacity, channel enables ----------------
    logic [PIX_W:0]     w_op_sum;
    logic [PIX_W-1:0]   w_op_eff;
    logic               w_chg;
    logic               r_sc_valid;
    logic [PIX_W-1:0]   r_sc_op;
    logic               r_sc_chg;
    logic               r_sc_t12;
    lofb_pkg::t_pix     r_sc_pix;

    assign w_op_sum = {1'b0, r_sa_pix.op} + r_sa_inc;
    assign w_op_eff = w_op_sum[PIX_W] ? lofb_pkg::PIX_MAX : w_op_sum[PIX_W-1:0];
    assign w_chg    = r_sa_pix.in_range && (w_op_eff != lofb_pkg::PIX_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc_valid <= 1'b0;
        end else begin
            r_sc_valid <= r_sa_valid;
        end
        r_sc_op  <= w_op_eff;
        r_sc_chg <= w_chg;
        // in YUV, chroma only at chroma sites and never with grayout
        r_sc_t12 <= w_chg && (!r_yuv || (!r_gray && r_sa_pix.site));
        r_sc_pix <= r_sa_pix;
    end

    // ---------------- stage D: weight products ----------------
    logic [NUM_CH-1:0][MUL_W-1:0] r_sd_pv;
    logic [NUM_CH-1:0][MUL_W-1:0] r_sd_pl;
    logic [NUM_CH-1:0][PIX_W-1:0] r_sd_v;
    logic [NUM_CH-1:0][PIX_W-1:0] r_sd_l;
    logic                         r_sd_valid;
    logic                         r_sd_zero;
    logic                         r_sd_chg;
    logic                         r_sd_t12;
    logic [PIX_W-1:0]             w_op_inv;

    assign w_op_inv = lofb_pkg::PIX_MAX - r_sc_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd_valid <= 1'b0;
        end else begin
            r_sd_valid <= r_sc_valid;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            r_sd_pv[c] <= MUL_W'(r_sc_pix.v[c]) * MUL_W'(r_sc_op);
            r_sd_pl[c] <= MUL_W'(r_sc_pix.l[c]) * MUL_W'(w_op_inv);
        end
        r_sd_v    <= r_sc_pix.v;
        r_sd_l    <= r_sc_pix.l;
        r_sd_zero <= (r_sc_op == '0);
        r_sd_chg  <= r_sc_chg;
        r_sd_t12  <= r_sc_t12;
    end

    // ---------------- stage E: /255, sum, select ----------------
    logic [NUM_CH-1:0][PIX_W-1:0] w_mix;
    logic [NUM_CH-1:0][PIX_W-1:0] n_out;
    logic [NUM_CH-1:0][PIX_W-1:0] r_out;
    logic                         r_out_valid;
    logic                         r_out_chg;

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_mix[c] = r_sd_zero ? r_sd_l[c] : (div255(r_sd_pv[c]) + div255(r_sd_pl[c]));
            if ((c == 0) ? r_sd_chg : r_sd_t12) begin
                n_out[c] = w_mix[c];
            end else begin
                n_out[c] = r_sd_v[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_chg   <= 1'b0;
        end else begin
            r_out_valid <= r_sd_valid;
            r_out_chg   <= r_sd_valid && r_sd_chg;
        end
        r_out <= n_out;
    end

    assign o_strobe      = r_out_valid;
    assign o_out_c0      = r_out[0];
    assign o_out_c1      = r_out[1];
    assign o_out_c2      = r_out[2];
    assign o_was_changed = r_out_chg;

endmodule

// ===== rtl/lofb_checker.sv =====
module lofb_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [lofb_pkg::PIX_W-1:0]    i_video_c0,
    input logic [lofb_pkg::PIX_W-1:0]    i_video_c1,
    input logic [lofb_pkg::PIX_W-1:0]    i_video_c2,
    input logic [lofb_pkg::PIX_W-1:0]    i_logo_opacity,
    input logic                          o_strobe,
    input logic [lofb_pkg::PIX_W-1:0]    o_out_c0,
    input logic [lofb_pkg::PIX_W-1:0]    o_out_c1,
    input logic [lofb_pkg::PIX_W-1:0]    o_out_c2,
    input logic                          o_was_changed
);

    // every request comes back exactly once, a fixed number of cycles later
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(lofb_pkg::LATENCY) o_strobe)
        else $error("request taken but no result strobe LATENCY cycles later");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, lofb_pkg::LATENCY))
        else $error("result strobe without a request taken LATENCY cycles earlier");

    // an untouched pixel is the video pixel of its own request
    a_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_was_changed) |->
            (o_out_c0 == $past(i_video_c0, lofb_pkg::LATENCY)) &&
            (o_out_c1 == $past(i_video_c1, lofb_pkg::LATENCY)) &&
            (o_out_c2 == $past(i_video_c2, lofb_pkg::LATENCY)))
        else $error("unchanged pixel differs from its video input");

    // the fade only raises opacity, so a clear logo pixel never changes anything
    a_clear_logo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && ($past(i_logo_opacity, lofb_pkg::LATENCY) == lofb_pkg::PIX_MAX))
            |-> !o_was_changed)
        else $error("fully transparent logo pixel reported as changed");

    a_changed_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_was_changed |-> o_strobe)
        else $error("was_changed raised without a result");

endmodule

bind logo_overlay_fade_blender_core lofb_checker u_lofb_checker (.*);

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 195;

    typedef struct packed {
        logic [lofb_pkg::FRAME_W-1:0]                   frame;
        logic [lofb_pkg::NUM_CH-1:0][lofb_pkg::PIX_W-1:0] video;
        logic [lofb_pkg::NUM_CH-1:0][lofb_pkg::PIX_W-1:0] logo;
        logic [lofb_pkg::PIX_W-1:0]                     opacity;
        logic                                           site;
    } t_pixel_in;

    typedef struct packed {
        logic [lofb_pkg::NUM_CH-1:0][lofb_pkg::PIX_W-1:0] px;
        logic                                           changed;
    } t_pixel_out;

    class overlay_scoreboard;
        logic [31:0] range_start;
        logic [31:0] range_end;
        logic [15:0] fade_in;
        logic [15:0] fade_out;
        logic        swap_rb;
        logic        yuv;
        logic        gray;
        t_pixel_out  due_q[$];
        int          fails;
        int          n_checked;
        int          n_changed;
        int          n_ramp;

        function new();
            range_start = '0;
            range_end   = '1;
            fade_in     = '0;
            fade_out    = '0;
            swap_rb     = 1'b0;
            yuv         = 1'b0;
            gray        = 1'b0;
            fails       = 0;
            n_checked   = 0;
            n_changed   = 0;
            n_ramp      = 0;
        endfunction

        function void set_reg(logic [lofb_pkg::CFG_IDX_W-1:0] idx,
                              logic [lofb_pkg::CFG_DATA_W-1:0] d);
            case (idx)
                lofb_pkg::CFG_RANGE_START:     range_start = d;
                lofb_pkg::CFG_RANGE_END:       range_end   = d;
                lofb_pkg::CFG_FADE_IN_FRAMES:  fade_in     = d[15:0];
                lofb_pkg::CFG_FADE_OUT_FRAMES: fade_out    = d[15:0];
                lofb_pkg::CFG_SWAP_RED_BLUE:   swap_rb     = d[0];
                lofb_pkg::CFG_YUV_MODE:        yuv         = d[0];
                lofb_pkg::CFG_GRAY_ONLY:       gray        = d[0];
                default: ;
            endcase
        endfunction

        function logic [lofb_pkg::PIX_W-1:0] mix_channel(logic [lofb_pkg::PIX_W-1:0] v,
                                                         logic [lofb_pkg::PIX_W-1:0] l,
                                                         logic [lofb_pkg::PIX_W-1:0] op);
            int unsigned a;
            int unsigned b;
            if (op == '0)
                return l;
            a = (int'(v) * int'(op)) / 255;
            b = (int'(l) * (255 - int'(op))) / 255;
            return lofb_pkg::PIX_W'(a + b);
        endfunction

        function t_pixel_out blend_pixel(t_pixel_in r);
            t_pixel_out                  res;
            logic [31:0]                 from_start;
            logic [31:0]                 to_end;
            longint unsigned             num;
            longint unsigned             den;
            longint unsigned             k;
            longint unsigned             inc;
            longint unsigned             eop;
            logic [lofb_pkg::PIX_W-1:0]  op;
            res.px      = r.video;
            res.changed = 1'b0;
            if (r.frame >= range_start && r.frame <= range_end) begin
                from_start = r.frame - range_start;
                to_end     = range_end - r.frame;
                num = 0;
                den = 0;
                // fade-in takes priority when both ramps cover the frame
                if (from_start < fade_in) begin
                    num = fade_in - from_start;
                    den = fade_in;
                end else if (to_end < fade_out) begin
                    num = fade_out - to_end;
                    den = fade_out;
                end
                eop = r.opacity;
                if (den != 0) begin
                    k   = (num << lofb_pkg::FADE_FRAC_BITS) / den;
                    inc = ((255 - eop) * k) >> lofb_pkg::FADE_FRAC_BITS;
                    eop = eop + inc;
                    if (eop > 255)
                        eop = 255;
                    n_ramp++;
                end
                op = eop[lofb_pkg::PIX_W-1:0];
                if (op != lofb_pkg::PIX_MAX) begin
                    res.changed = 1'b1;
                    if (yuv) begin
                        res.px[0] = mix_channel(r.video[0], r.logo[0], op);
                        if (!gray && r.site) begin
                            res.px[1] = mix_channel(r.video[1], r.logo[1], op);
                            res.px[2] = mix_channel(r.video[2], r.logo[2], op);
                        end
                    end else if (swap_rb) begin
                        res.px[0] = mix_channel(r.video[0], r.logo[2], op);
                        res.px[1] = mix_channel(r.video[1], r.logo[1], op);
                        res.px[2] = mix_channel(r.video[2], r.logo[0], op);
                    end else begin
                        for (int c = 0; c < lofb_pkg::NUM_CH; c++)
                            res.px[c] = mix_channel(r.video[c], r.logo[c], op);
                    end
                end
            end
            return res;
        endfunction

        function void note_request(t_pixel_in r);
            t_pixel_out e;
            e = blend_pixel(r);
            if (e.changed)
                n_changed++;
            due_q.push_back(e);
        endfunction

        function void check_result(t_pixel_out got);
            t_pixel_out e;
            if (due_q.size() == 0) begin
                $error("result strobe with no request outstanding");
                fails++;
                return;
            end
            e = due_q.pop_front();
            n_checked++;
            for (int c = 0; c < lofb_pkg::NUM_CH; c++) begin
                if (got.px[c] !== e.px[c]) begin
                    $error("out_c%0d: expected %0d, got %0d", c, e.px[c], got.px[c]);
                    fails++;
                end
            end
            if (got.changed !== e.changed) begin
                $error("was_changed: expected %0d, got %0d", e.changed, got.changed);
                fails++;
            end
        endfunction

        function int outstanding();
            return due_q.size();
        endfunction

        function int closing_fails();
            if (due_q.size() != 0) begin
                $error("%0d results never arrived", due_q.size());
                fails++;
            end
            return fails;
        endfunction
    endclass

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [lofb_pkg::FRAME_W-1:0]      i_frame_number;
    logic [lofb_pkg::PIX_W-1:0]        i_video_c0;
    logic [lofb_pkg::PIX_W-1:0]        i_video_c1;
    logic [lofb_pkg::PIX_W-1:0]        i_video_c2;
    logic [lofb_pkg::PIX_W-1:0]        i_logo_c0;
    logic [lofb_pkg::PIX_W-1:0]        i_logo_c1;
    logic [lofb_pkg::PIX_W-1:0]        i_logo_c2;
    logic [lofb_pkg::PIX_W-1:0]        i_logo_opacity;
    logic                              i_chroma_site;
    logic                              i_cfg_we;
    logic [lofb_pkg::CFG_IDX_W-1:0]    i_cfg_idx;
    logic [lofb_pkg::CFG_DATA_W-1:0]   i_cfg_wdata;
    logic                              o_strobe;
    logic [lofb_pkg::PIX_W-1:0]        o_out_c0;
    logic [lofb_pkg::PIX_W-1:0]        o_out_c1;
    logic [lofb_pkg::PIX_W-1:0]        o_out_c2;
    logic                              o_was_changed;

    overlay_scoreboard sb = new();
    int unsigned       cycle_count = 0;
    int                n_settings = 0;

    logo_overlay_fade_blender_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_frame_number (i_frame_number),
        .i_video_c0     (i_video_c0),
        .i_video_c1     (i_video_c1),
        .i_video_c2     (i_video_c2),
        .i_logo_c0      (i_logo_c0),
        .i_logo_c1      (i_logo_c1),
        .i_logo_c2      (i_logo_c2),
        .i_logo_opacity (i_logo_opacity),
        .i_chroma_site  (i_chroma_site),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_out_c0       (o_out_c0),
        .o_out_c1       (o_out_c1),
        .o_out_c2       (o_out_c2),
        .o_was_changed  (o_was_changed)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL logo_overlay_fade_blender_core");
            $finish;
        end
    end

    // request accepted
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy)
            sb.note_request('{i_frame_number, {i_video_c2, i_video_c1, i_video_c0},
                              {i_logo_c2, i_logo_c1, i_logo_c0}, i_logo_opacity,
                              i_chroma_site});
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result('{{o_out_c2, o_out_c1, o_out_c0}, o_was_changed});
    end

    task automatic send_pixel(input t_pixel_in r);
        @(negedge i_clk);
        i_frame_number = r.frame;
        i_video_c0     = r.video[0];
        i_video_c1     = r.video[1];
        i_video_c2     = r.video[2];
        i_logo_c0      = r.logo[0];
        i_logo_c1      = r.logo[1];
        i_logo_c2      = r.logo[2];
        i_logo_opacity = r.opacity;
        i_chroma_site  = r.site;
        start          = 1'b1;
        do
            @(posedge i_clk);
        while (busy);
    endtask

    task automatic idle_cycle();
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic drain();
        idle_cycle();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lofb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lofb_pkg::CFG_DATA_W-1:0] d);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = d;
        sb.set_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    task automatic apply_setting(input logic [31:0] rs, input logic [31:0] re,
                                 input logic [15:0] fin, input logic [15:0] fout,
                                 input logic swap, input logic yuv, input logic gray);
        drain();
        write_reg(lofb_pkg::CFG_RANGE_START, rs);
        write_reg(lofb_pkg::CFG_RANGE_END, re);
        write_reg(lofb_pkg::CFG_FADE_IN_FRAMES, 32'(fin));
        write_reg(lofb_pkg::CFG_FADE_OUT_FRAMES, 32'(fout));
        write_reg(lofb_pkg::CFG_SWAP_RED_BLUE, 32'(swap));
        write_reg(lofb_pkg::CFG_YUV_MODE, 32'(yuv));
        write_reg(lofb_pkg::CFG_GRAY_ONLY, 32'(gray));
        n_settings++;
    endtask

    function automatic t_pixel_in pixel_req(logic [31:0] f, logic [23:0] v, logic [23:0] l,
                                            logic [7:0] op, logic site);
        t_pixel_in r;
        r.frame   = f;
        r.video   = v;
        r.logo    = l;
        r.opacity = op;
        r.site    = site;
        return r;
    endfunction

    // frames are steered towards the ramps and the range edges
    function automatic t_pixel_in next_pixel();
        t_pixel_in       r;
        longint unsigned span;
        logic [31:0]     rs;
        logic [31:0]     re;
        rs = sb.range_start;
        re = sb.range_end;
        case ($urandom_range(0, 9))
            0, 1: r.frame = rs + $urandom_range(0, 32'(sb.fade_in) + 2);
            2, 3: r.frame = re - $urandom_range(0, 32'(sb.fade_out) + 2);
            4:    r.frame = rs - $urandom_range(1, 3);
            5:    r.frame = re + $urandom_range(1, 3);
            6:    r.frame = $urandom();
            default: begin
                if (re >= rs) begin
                    span    = 64'(re - rs) + 1;
                    r.frame = rs + 32'(64'($urandom()) % span);
                end else begin
                    r.frame = $urandom();
                end
            end
        endcase
        for (int c = 0; c < lofb_pkg::NUM_CH; c++) begin
            r.video[c] = 8'($urandom_range(0, 255));
            r.logo[c]  = 8'($urandom_range(0, 255));
        end
        case ($urandom_range(0, 7))
            0:       r.opacity = 8'd0;
            1:       r.opacity = lofb_pkg::PIX_MAX;
            2:       r.opacity = 8'($urandom_range(1, 3));
            3:       r.opacity = 8'($urandom_range(252, 254));
            default: r.opacity = 8'($urandom_range(0, 255));
        endcase
        r.site = 1'($urandom_range(0, 1));
        return r;
    endfunction

    initial begin
        int idle_pct;
        logic [31:0] rs;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_frame_number = '0;
        i_video_c0     = '0;
        i_video_c1     = '0;
        i_video_c2     = '0;
        i_logo_c0      = '0;
        i_logo_c1      = '0;
        i_logo_c2      = '0;
        i_logo_opacity = '0;
        i_chroma_site  = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_wdata    = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // defaults: whole frame range, no ramps, RGB
        send_pixel(pixel_req(32'd0, 24'h000000, 24'hFFFFFF, 8'd0, 1'b0));
        send_pixel(pixel_req(32'hFFFF_FFFF, 24'hFFFFFF, 24'h000000, 8'd255, 1'b1));
        send_pixel(pixel_req(32'd7, 24'hFFFFFF, 24'hFFFFFF, 8'd1, 1'b0));
        send_pixel(pixel_req(32'd8, 24'h000000, 24'hFFFFFF, 8'd254, 1'b1));
        send_pixel(pixel_req(32'd9, 24'h38220C, 24'h3264C8, 8'd128, 1'b0));

        // ramps at both ends, red/blue swap
        apply_setting(32'd1000, 32'd5000, 16'd100, 16'd200, 1'b1, 1'b0, 1'b0);
        send_pixel(pixel_req(32'd999, 24'h102030, 24'hA0B0C0, 8'd0, 1'b0));
        send_pixel(pixel_req(32'd5001, 24'h102030, 24'hA0B0C0, 8'd0, 1'b0));
        send_pixel(pixel_req(32'd1000, 24'h102030, 24'hA0B0C0, 8'd0, 1'b0));
        send_pixel(pixel_req(32'd1001, 24'h102030, 24'hA0B0C0, 8'd0, 1'b0));
        send_pixel(pixel_req(32'd1099, 24'h102030, 24'hA0B0C0, 8'd10, 1'b0));
        send_pixel(pixel_req(32'd1100, 24'h102030, 24'hA0B0C0, 8'd0, 1'b0));
        send_pixel(pixel_req(32'd5000, 24'h102030, 24'hA0B0C0, 8'd40, 1'b0));
        send_pixel(pixel_req(32'd4801, 24'h102030, 24'hA0B0C0, 8'd0, 1'b0));
        send_pixel(pixel_req(32'd4800, 24'h102030, 24'hA0B0C0, 8'd77, 1'b0));

        // both ramps cover the frame: fade-in must win
        apply_setting(32'd100, 32'd110, 16'd20, 16'd20, 1'b0, 1'b0, 1'b0);
        send_pixel(pixel_req(32'd105, 24'h804020, 24'h20F0FF, 8'd5, 1'b0));

        // YUV: swap has no effect, chroma only at chroma sites
        apply_setting(32'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0);
        send_pixel(pixel_req(32'd3, 24'h112233, 24'hCCDDEE, 8'd0, 1'b1));
        send_pixel(pixel_req(32'd3, 24'h112233, 24'hCCDDEE, 8'd60, 1'b0));
        send_pixel(pixel_req(32'd4, 24'hFF00FF, 24'h00FF00, 8'd200, 1'b1));

        apply_setting(32'd0, 32'hFFFF_FFFF, 16'd0, 16'd0, 1'b0, 1'b1, 1'b1);
        send_pixel(pixel_req(32'd4, 24'h112233, 24'hCCDDEE, 8'd30, 1'b1));

        // start beyond end: nothing is in range
        apply_setting(32'd50, 32'd40, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
        send_pixel(pixel_req(32'd45, 24'h123456, 24'h654321, 8'd0, 1'b1));

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: apply_setting(32'd1000, 32'd5000, 16'd100, 16'd200, 1'b0, 1'b0, 1'b0);
                1: apply_setting(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0);
                2: begin
                    rs = $urandom();
                    apply_setting(rs, rs + $urandom_range(0, 400),
                                  16'($urandom_range(1, 60)), 16'($urandom_range(1, 60)),
                                  1'b0, 1'b1, 1'b0);
                end
                3: begin
                    rs = $urandom_range(0, 1000);
                    apply_setting(rs, rs + $urandom_range(0, 200), 16'd1, 16'd1,
                                  1'b1, 1'b1, 1'b1);
                end
                4: apply_setting(32'd5000, 32'd4000, 16'd10, 16'd10, 1'b0, 1'b0, 1'b0);
                5: begin
                    rs = $urandom();
                    apply_setting(rs, rs, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0);
                end
                6: apply_setting(32'd100, 32'd150, 16'd60, 16'd60,
                                 1'($urandom_range(0, 1)), 1'b0, 1'b0);
                7: apply_setting(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'd300, 16'd300,
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)));
                default: apply_setting($urandom(), $urandom(),
                                       16'($urandom_range(0, 65535)),
                                       16'($urandom_range(0, 65535)),
                                       1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)),
                                       1'($urandom_range(0, 1)));
            endcase
            idle_pct = (p < 3) ? 19 : (p < 6) ? 76 : 0;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                while ($urandom_range(0, 99) < idle_pct)
                    idle_cycle();
                send_pixel(next_pixel());
            end
        end

        idle_cycle();
        while (sb.outstanding() != 0)
            @(posedge i_clk);
        repeat (lofb_pkg::LATENCY + 4) @(posedge i_clk);

        $display("%0d pixels checked over %0d register settings (reset default included)",
                 sb.n_checked, n_settings + 1);
        $display("%0d took a logo contribution, %0d fell on a fade ramp",
                 sb.n_changed, sb.n_ramp);
        if (sb.closing_fails() == 0)
            $display("PASS logo_overlay_fade_blender_core");
        else
            $display("FAIL logo_overlay_fade_blender_core");
        $finish;
    end

endmodule
